// ===== hdl/life_cell_stencil_macros.svh =====
// Assertion macros for the life cell stencil checker.
`ifndef LIFE_CELL_STENCIL_MACROS_SVH
`define LIFE_CELL_STENCIL_MACROS_SVH

// same-cycle implication, masked during reset
`define LCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define LCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// what must hold on the cycle after a reset edge
`define LCS_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lcs_pkg.sv =====
`default_nettype none

package lcs_pkg;

    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int DIM_W      = 13;
    localparam int OUT_W      = 10;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;
    localparam int WIN_W      = 9;
    localparam int CNT_W      = 4;
    localparam int CENTER_BIT = 4;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] GRID_RESET   = 11'd1024;
    localparam logic [DIM_W-1:0] MIN_DIM      = 13'd3;
    localparam logic [CNT_W-1:0] BIRTH_COUNT  = 4'd3;
    localparam logic [CNT_W-1:0] KEEP_COUNT   = 4'd2;

    typedef logic [WIN_W-1:0] window_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] ext;
        ext = DIM_W'(v);
        if (ext < MIN_DIM) begin
            return MIN_DIM;
        end else if (ext > hi) begin
            return hi;
        end
        return ext;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/life_cell_stencil.sv =====
// Game of Life (B3/S23) stencil on a raster stream of cells. One cell is taken per
// transaction in row-major order, and one transaction per clock is sustained while
// m_tready holds no result back. For each interior cell (rows 1..H-2, columns 1..W-2)
// a result carrying the next-generation state is registered at the output as the input
// cell one row and one column ahead of it leaves the input stage; border cells give
// no result. W and H are the grid_width and grid_height registers clamped to
// [3, MAX_WIDTH] and [3, MAX_HEIGHT]; write them only while idle. m_tlast marks the
// last result of a frame. The two previous rows live in a single MAX_WIDTH x 2 line
// memory, read as a cell is taken and written back as it leaves the input stage; its
// contents are undefined after reset until the first two rows of a frame have passed.
`default_nettype none

module life_cell_stencil #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [lcs_pkg::S_TDATA_W-1:0]     s_tdata,   // [0] cell_alive
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [lcs_pkg::M_TDATA_W-1:0]     m_tdata,   // [9:0] cell_row, [19:10] cell_col,
                                                         // [20] next_alive
    output logic                              m_tlast,   // frame_done
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [lcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [lcs_pkg::CFG_W-1:0]         cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int OUT_W = lcs_pkg::OUT_W;
    localparam int DIM_W = lcs_pkg::DIM_W;

    logic [lcs_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0]          w_eff, h_eff;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             row_end, frame_end, emit;

    logic [1:0]       line_mem [MAX_WIDTH];
    logic [1:0]       rd_reg;

    logic             a_valid_reg;
    logic             a_bit_reg;
    logic             a_last_reg;
    logic             a_emit_reg;
    logic [COL_W-1:0] a_col_reg;
    logic [ROW_W-1:0] a_row_reg;

    lcs_pkg::window_t window_reg, window_next;
    logic             rule_alive;

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_row_reg, m_col_reg;
    logic             m_alive_reg, m_last_reg;

    logic             s_fire, out_free, a_advance;
    logic [COL_W-1:0] col_m1;
    logic [ROW_W-1:0] row_m1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lcs_pkg::GRID_RESET;
            height_reg <= lcs_pkg::GRID_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                lcs_pkg::REG_GRID_WIDTH:  width_reg  <= cfg_data;
                lcs_pkg::REG_GRID_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = lcs_pkg::clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign h_eff = lcs_pkg::clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));

    // handshake: input stage frees when its item moves on in the same cycle
    assign out_free  = !m_valid_reg || m_tready;
    assign a_advance = a_valid_reg && out_free;
    assign s_tready  = !a_valid_reg || out_free;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        row_end   = (DIM_W'(col_reg) + DIM_W'(1) >= w_eff);
        frame_end = row_end && (DIM_W'(row_reg) + DIM_W'(1) >= h_eff);
        emit      = (DIM_W'(row_reg) >= DIM_W'(2)) && (DIM_W'(col_reg) >= DIM_W'(2));
        col_next  = row_end ? '0 : col_reg + COL_W'(1);
        row_next  = frame_end ? '0 : (row_end ? row_reg + ROW_W'(1) : row_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_fire) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // entry: [1] row - 2, [0] row - 1
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_reg <= line_mem[col_reg];
        end
        if (a_advance) begin
            line_mem[a_col_reg] <= {rd_reg[0], a_bit_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_fire) begin
            a_valid_reg <= 1'b1;
        end else if (a_advance) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_bit_reg  <= s_tdata[0];
            a_last_reg <= frame_end;
            a_emit_reg <= emit;
            a_col_reg  <= col_reg;
            a_row_reg  <= row_reg;
        end
    end

    assign window_next = {a_bit_reg, rd_reg[0], rd_reg[1], window_reg[8:3]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (a_advance) begin
            window_reg <= window_next;
        end
    end

    lcs_rule u_rule (
        .window     (window_next),
        .next_alive (rule_alive)
    );

    assign col_m1 = a_col_reg - COL_W'(1);
    assign row_m1 = a_row_reg - ROW_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_advance) begin
            m_valid_reg <= a_emit_reg;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_advance && a_emit_reg) begin
            m_row_reg   <= OUT_W'(row_m1);
            m_col_reg   <= OUT_W'(col_m1);
            m_alive_reg <= rule_alive;
            m_last_reg  <= a_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_alive_reg, m_col_reg, m_row_reg};

endmodule

`default_nettype wire

// ===== hdl/lcs_rule.sv =====
`default_nettype none

// B3/S23 on a 3x3 window; bit 4 is the center cell
module lcs_rule (
    input  wire lcs_pkg::window_t window,
    output logic                  next_alive
);

    logic [lcs_pkg::CNT_W-1:0] neighbors;

    always_comb begin
        neighbors = '0;
        for (int i = 0; i < lcs_pkg::WIN_W; i++) begin
            if (i != lcs_pkg::CENTER_BIT) begin
                neighbors = neighbors + lcs_pkg::CNT_W'(window[i]);
            end
        end
        if (neighbors == lcs_pkg::BIRTH_COUNT) begin
            next_alive = 1'b1;
        end else if (neighbors == lcs_pkg::KEEP_COUNT) begin
            next_alive = window[lcs_pkg::CENTER_BIT];
        end else begin
            next_alive = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lcs_checker.sv =====
`default_nettype none

`include "life_cell_stencil_macros.svh"

module lcs_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tready,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [lcs_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire                           m_tlast
);

    `LCS_ASSERT_RST(a_reset_clears_out, !m_tvalid, "result valid right after reset")

    `LCS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tlast),
                    "stalled result changed")

    `LCS_ASSERT_IMP(a_no_stall_when_drained, m_tready, s_tready,
                    "input stalled while output drains")

    `LCS_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[23:21] == 3'b000,
                    "result padding bits not zero")

endmodule

bind life_cell_stencil lcs_checker u_lcs_checker (.*);

`default_nettype wire
